### src/whp_pkg.sv
`default_nettype none

package whp_pkg;

   // parse phases
   typedef enum logic [3:0] {
      PH_RIFF    = 4'd0,
      PH_RSIZE   = 4'd1,
      PH_WAVE    = 4'd2,
      PH_CID     = 4'd3,
      PH_CSIZE   = 4'd4,
      PH_FMT     = 4'd5,
      PH_SKIP    = 4'd6,
      PH_PAYLOAD = 4'd7,
      PH_DONE    = 4'd8
   } phase_type;

   // result status codes
   typedef enum logic [3:0] {
      ST_HEADER          = 4'd0,
      ST_ACCEPTED        = 4'd1,
      ST_PAYLOAD         = 4'd2,
      ST_BAD_TAG         = 4'd3,
      ST_SHORT_FMT       = 4'd4,
      ST_DATA_BEFORE_FMT = 4'd5,
      ST_UNSUPPORTED     = 4'd6,
      ST_TRUNCATED       = 4'd7,
      ST_IGNORED         = 4'd8
   } status_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_WANT_FORMAT   = 2'd0,
      CSR_WANT_CHANNELS = 2'd1,
      CSR_WANT_RATE     = 2'd2,
      CSR_WANT_BITS     = 2'd3
   } csr_index_type;

   localparam int CSR_DATA_W = 32;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   // header fields are four bytes, fmt capture covers sixteen
   localparam logic [3:0]  FIELD_BYTES = 4'd4;
   localparam logic [3:0]  FMT_LAST    = 4'd15;
   localparam logic [31:0] FMT_BYTES   = 32'd16;

   localparam logic [15:0] RESET_FORMAT   = 16'd1;
   localparam logic [15:0] RESET_CHANNELS = 16'd2;
   localparam logic [31:0] RESET_RATE     = 32'd44100;
   localparam logic [15:0] RESET_BITS     = 16'd16;

   typedef struct packed {
      logic [15:0] format;
      logic [15:0] channels;
      logic [31:0] rate;
      logic [15:0] bits;
   } want_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  payload_byte;
      logic        payload_last;
      logic [31:0] data_size;
      logic [31:0] data_offset;
   } result_type;

endpackage

`default_nettype wire

### src/whp_req_if.sv
`default_nettype none

interface whp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;
   logic       final_byte;

   modport source (output valid, data_byte, first_byte, final_byte, input ready);
   modport sink   (input valid, data_byte, first_byte, final_byte, output ready);
endinterface

`default_nettype wire

### src/whp_rsp_if.sv
`default_nettype none

interface whp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [7:0]  payload_byte;
   logic        payload_last;
   logic [31:0] data_size;
   logic [31:0] data_offset;

   modport source (output valid, status, payload_byte, payload_last, data_size, data_offset,
                   input ready);
   modport sink   (input valid, status, payload_byte, payload_last, data_size, data_offset,
                   output ready);
endinterface

`default_nettype wire

### src/whp_csr.sv
`default_nettype none

module whp_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [1:0]                     csr_index,
   input  wire logic [whp_pkg::CSR_DATA_W-1:0] csr_wdata,
   output whp_pkg::want_type                   want
);

   whp_pkg::want_type want_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         want_ff.format   <= whp_pkg::RESET_FORMAT;
         want_ff.channels <= whp_pkg::RESET_CHANNELS;
         want_ff.rate     <= whp_pkg::RESET_RATE;
         want_ff.bits     <= whp_pkg::RESET_BITS;
      end else if (csr_we) begin
         case (whp_pkg::csr_index_type'(csr_index))
            whp_pkg::CSR_WANT_FORMAT:   want_ff.format   <= csr_wdata[15:0];
            whp_pkg::CSR_WANT_CHANNELS: want_ff.channels <= csr_wdata[15:0];
            whp_pkg::CSR_WANT_RATE:     want_ff.rate     <= csr_wdata[31:0];
            whp_pkg::CSR_WANT_BITS:     want_ff.bits     <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign want = want_ff;

endmodule

`default_nettype wire

### src/whp_parse.sv
`default_nettype none

module whp_parse (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic [7:0]  data_byte,
   input  wire logic        first_byte,
   input  wire logic        final_byte,
   input  wire whp_pkg::want_type want,
   output whp_pkg::result_type result
);

   whp_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic [3:0]  fc_ff, fc_in, cur_fc, fc_inc;
   logic [31:0] tag_ff, tag_in, cur_tag, tag_new;
   logic [31:0] size_ff, size_in, cur_size, size_new;
   logic [31:0] skip_ff, skip_in, cur_skip;
   logic [15:0] code_ff, code_in, cur_code;
   logic [15:0] chans_ff, chans_in, cur_chans;
   logic [31:0] hz_ff, hz_in, cur_hz;
   logic [15:0] depth_ff, depth_in, cur_depth;
   logic        have_ff, have_in, cur_have;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] left_ff, left_in, cur_left, left_dec;
   logic [31:0] fsize_ff, fsize_in;
   logic [31:0] foffs_ff, foffs_in;

   logic        field_done, tag_ok, is_fmt, is_data, fmt_short, mismatch;
   logic [31:0] fmt_rest;

   // a first byte restarts from a clean parse
   always_comb begin
      cur_phase = first_byte ? whp_pkg::PH_RIFF : phase_ff;
      cur_fc    = first_byte ? 4'd0  : fc_ff;
      cur_tag   = first_byte ? 32'd0 : tag_ff;
      cur_size  = first_byte ? 32'd0 : size_ff;
      cur_skip  = first_byte ? 32'd0 : skip_ff;
      cur_code  = first_byte ? 16'd0 : code_ff;
      cur_chans = first_byte ? 16'd0 : chans_ff;
      cur_hz    = first_byte ? 32'd0 : hz_ff;
      cur_depth = first_byte ? 16'd0 : depth_ff;
      cur_have  = first_byte ? 1'b0  : have_ff;
      cur_left  = first_byte ? 32'd0 : left_ff;
   end

   assign fc_inc     = cur_fc + 4'd1;
   assign field_done = (fc_inc == whp_pkg::FIELD_BYTES);
   assign tag_new    = {cur_tag[23:0], data_byte};
   assign size_new   = {data_byte, cur_size[31:8]};
   assign tag_ok     = (tag_new == ((cur_phase == whp_pkg::PH_RIFF) ?
                                    whp_pkg::TAG_RIFF : whp_pkg::TAG_WAVE));
   assign is_fmt     = (cur_tag == whp_pkg::TAG_FMT);
   assign is_data    = (cur_tag == whp_pkg::TAG_DATA);
   assign fmt_short  = (size_new < whp_pkg::FMT_BYTES);
   assign mismatch   = (cur_code != want.format) || (cur_chans != want.channels) ||
                       (cur_hz != want.rate) || (cur_depth != want.bits) ||
                       (size_new == 32'd0);
   assign fmt_rest   = cur_size - whp_pkg::FMT_BYTES;
   assign left_dec   = cur_left - 32'd1;

   // next state
   always_comb begin
      phase_in = cur_phase;
      fc_in    = cur_fc;
      tag_in   = cur_tag;
      size_in  = cur_size;
      skip_in  = cur_skip;
      code_in  = cur_code;
      chans_in = cur_chans;
      hz_in    = cur_hz;
      depth_in = cur_depth;
      have_in  = cur_have;
      left_in  = cur_left;
      pos_in   = (first_byte ? 32'd0 : pos_ff) + 32'd1;
      fsize_in = first_byte ? 32'd0 : fsize_ff;
      foffs_in = first_byte ? 32'd0 : foffs_ff;

      case (cur_phase)
         whp_pkg::PH_RIFF, whp_pkg::PH_WAVE: begin
            tag_in = tag_new;
            fc_in  = fc_inc;
            if (field_done) begin
               fc_in = 4'd0;
               if (!tag_ok)
                  phase_in = whp_pkg::PH_DONE;
               else if (cur_phase == whp_pkg::PH_RIFF)
                  phase_in = whp_pkg::PH_RSIZE;
               else
                  phase_in = whp_pkg::PH_CID;
            end
         end
         whp_pkg::PH_RSIZE: begin
            fc_in = fc_inc;
            if (field_done) begin
               fc_in    = 4'd0;
               phase_in = whp_pkg::PH_WAVE;
            end
         end
         whp_pkg::PH_CID: begin
            tag_in = tag_new;
            fc_in  = fc_inc;
            if (field_done) begin
               fc_in    = 4'd0;
               phase_in = whp_pkg::PH_CSIZE;
            end
         end
         whp_pkg::PH_CSIZE: begin
            size_in = size_new;
            fc_in   = fc_inc;
            if (field_done) begin
               fc_in = 4'd0;
               if (is_fmt) begin
                  phase_in = fmt_short ? whp_pkg::PH_DONE : whp_pkg::PH_FMT;
               end else if (is_data) begin
                  fsize_in = size_new;
                  foffs_in = pos_in;
                  if (!cur_have || mismatch) begin
                     phase_in = whp_pkg::PH_DONE;
                  end else begin
                     left_in  = size_new;
                     phase_in = whp_pkg::PH_PAYLOAD;
                  end
               end else begin
                  // skip the body of an unknown chunk plus its pad byte
                  skip_in  = size_new;
                  fc_in    = {3'd0, size_new[0]};
                  phase_in = (size_new == 32'd0 && !size_new[0]) ?
                             whp_pkg::PH_CID : whp_pkg::PH_SKIP;
               end
            end
         end
         whp_pkg::PH_FMT: begin
            case (cur_fc)
               4'd0:  code_in[7:0]   = data_byte;
               4'd1:  code_in[15:8]  = data_byte;
               4'd2:  chans_in[7:0]  = data_byte;
               4'd3:  chans_in[15:8] = data_byte;
               4'd4:  hz_in[7:0]     = data_byte;
               4'd5:  hz_in[15:8]    = data_byte;
               4'd6:  hz_in[23:16]   = data_byte;
               4'd7:  hz_in[31:24]   = data_byte;
               4'd14: depth_in[7:0]  = data_byte;
               4'd15: depth_in[15:8] = data_byte;
               default: ;
            endcase
            if (cur_fc == whp_pkg::FMT_LAST) begin
               have_in  = 1'b1;
               skip_in  = fmt_rest;
               fc_in    = {3'd0, cur_size[0]};
               phase_in = (fmt_rest == 32'd0 && !cur_size[0]) ?
                          whp_pkg::PH_CID : whp_pkg::PH_SKIP;
            end else begin
               fc_in = fc_inc;
            end
         end
         whp_pkg::PH_SKIP: begin
            if (cur_skip != 32'd0)
               skip_in = cur_skip - 32'd1;
            else
               fc_in = 4'd0;
            if ((cur_skip == 32'd0 || cur_skip == 32'd1) &&
                (cur_skip != 32'd0 ? cur_fc == 4'd0 : 1'b1))
               phase_in = whp_pkg::PH_CID;
         end
         whp_pkg::PH_PAYLOAD: begin
            left_in = left_dec;
            if (left_dec == 32'd0 || final_byte)
               phase_in = whp_pkg::PH_DONE;
         end
         default: phase_in = whp_pkg::PH_DONE;
      endcase

      if (final_byte)
         phase_in = whp_pkg::PH_DONE;
   end

   // result of this byte
   always_comb begin
      result.status       = whp_pkg::ST_HEADER;
      result.payload_byte = 8'd0;
      result.payload_last = 1'b0;
      result.data_size    = fsize_in;
      result.data_offset  = foffs_in;

      case (cur_phase)
         whp_pkg::PH_RIFF, whp_pkg::PH_WAVE: begin
            if (field_done && !tag_ok)
               result.status = whp_pkg::ST_BAD_TAG;
         end
         whp_pkg::PH_CSIZE: begin
            if (field_done) begin
               if (is_fmt) begin
                  if (fmt_short)
                     result.status = whp_pkg::ST_SHORT_FMT;
               end else if (is_data) begin
                  if (!cur_have)
                     result.status = whp_pkg::ST_DATA_BEFORE_FMT;
                  else if (mismatch)
                     result.status = whp_pkg::ST_UNSUPPORTED;
                  else
                     result.status = whp_pkg::ST_ACCEPTED;
               end
            end
         end
         whp_pkg::PH_RSIZE, whp_pkg::PH_CID, whp_pkg::PH_FMT, whp_pkg::PH_SKIP: ;
         whp_pkg::PH_PAYLOAD: begin
            result.status       = whp_pkg::ST_PAYLOAD;
            result.payload_byte = data_byte;
            result.payload_last = (left_dec == 32'd0) || final_byte;
         end
         default: result.status = whp_pkg::ST_IGNORED;
      endcase

      // truncation only tags a byte that reports nothing else
      if (final_byte && result.status == whp_pkg::ST_HEADER)
         result.status = whp_pkg::ST_TRUNCATED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= whp_pkg::PH_RIFF;
         fc_ff    <= 4'd0;
         tag_ff   <= 32'd0;
         size_ff  <= 32'd0;
         skip_ff  <= 32'd0;
         code_ff  <= 16'd0;
         chans_ff <= 16'd0;
         hz_ff    <= 32'd0;
         depth_ff <= 16'd0;
         have_ff  <= 1'b0;
         pos_ff   <= 32'd0;
         left_ff  <= 32'd0;
         fsize_ff <= 32'd0;
         foffs_ff <= 32'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         fc_ff    <= fc_in;
         tag_ff   <= tag_in;
         size_ff  <= size_in;
         skip_ff  <= skip_in;
         code_ff  <= code_in;
         chans_ff <= chans_in;
         hz_ff    <= hz_in;
         depth_ff <= depth_in;
         have_ff  <= have_in;
         pos_ff   <= pos_in;
         left_ff  <= left_in;
         fsize_ff <= fsize_in;
         foffs_ff <= foffs_in;
      end
   end

endmodule

`default_nettype wire

### src/wave_header_parser.sv
// byte-serial RIFF/WAVE header parser: one file byte per req transaction and exactly
// one rsp transaction per byte, in order. the parser checks the RIFF and WAVE tags,
// walks chunk headers (little-endian sizes, odd sizes skip a pad byte), captures the
// format fields of each fmt chunk and, on the data chunk header, reports accepted or
// an error against the csr_ format registers, then passes the payload bytes through
// and marks the last one. throughput is one byte per clock while rsp ready stays
// high; a stalled result holds the result register and then the input register, so
// two transactions wait inside before req ready drops. each byte passes the input
// register, then the parse logic feeding the result register.
// a byte with first_byte set restarts the parse at file offset zero. configuration
// writes are only allowed while no transaction is in flight.
`default_nettype none

module wave_header_parser (
   input  wire logic                           clock,
   input  wire logic                           reset,
   whp_req_if.sink                             req_chan,
   whp_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_we,
   input  wire logic [1:0]                     csr_index,
   input  wire logic [whp_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;
   logic       in_final_ff;

   // result stage
   logic                 out_valid_ff, out_valid_in;
   whp_pkg::result_type  out_ff;

   whp_pkg::want_type    want;
   whp_pkg::result_type  result;

   logic out_take;   // result register can load this cycle
   logic in_take;    // input register can load this cycle
   logic step;       // parser consumes the byte in the input register

   assign out_take = !out_valid_ff || rsp_chan.ready;
   assign in_take  = !in_valid_ff || out_take;
   assign step     = in_valid_ff && out_take;

   assign req_chan.ready = in_take;

   always_comb begin
      in_valid_in  = in_take ? req_chan.valid : in_valid_ff;
      out_valid_in = out_take ? in_valid_ff : out_valid_ff;
   end

   // format registers
   whp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .want      (want)
   );

   // parse state and per-byte result logic
   whp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .data_byte  (in_byte_ff),
      .first_byte (in_first_ff),
      .final_byte (in_final_ff),
      .want       (want),
      .result     (result)
   );

   // handshake control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_chan.valid && in_take) begin
         in_byte_ff  <= req_chan.data_byte;
         in_first_ff <= req_chan.first_byte;
         in_final_ff <= req_chan.final_byte;
      end
      if (step)
         out_ff <= result;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.status       = out_ff.status;
   assign rsp_chan.payload_byte = out_ff.payload_byte;
   assign rsp_chan.payload_last = out_ff.payload_last;
   assign rsp_chan.data_size    = out_ff.data_size;
   assign rsp_chan.data_offset  = out_ff.data_offset;

endmodule

`default_nettype wire

### tb/wave_header_parser_tb.sv
`timescale 1ns / 100ps

module wave_header_parser_tb;
   import whp_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 6;
   localparam int IDLE_LIMIT    = 2000;   // cycles with no transaction on either side
   localparam int SETTLE_CYCLES = 6;
   localparam int LONG_HOLD     = 200;    // receiver hold-off, well past the parser's buffering

   // one file byte as offered on the req channel
   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       final_byte;
   } file_byte_type;

   // ways a random file gets damaged
   typedef enum {FLAW_NONE, FLAW_BIT, FLAW_CUT, FLAW_SHORT_FMT, FLAW_NO_FMT} flaw_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [1:0]            csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   whp_req_if req ();
   whp_rsp_if rsp ();

   wave_header_parser DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // bytes waiting for the driver, results waiting for the monitor
   file_byte_type pending_bytes[$];
   result_type    expected_results[$];
   logic [7:0]    file_buf[$];

   // mirror of the format registers
   want_type required_fmt;

   // parser state as the scoreboard sees it
   phase_type   file_phase;
   logic [3:0]  byte_count;
   logic [31:0] tag_window;
   logic [31:0] size_window;
   logic [31:0] skip_count;
   logic [15:0] cap_format;
   logic [15:0] cap_channels;
   logic [31:0] cap_rate;
   logic [15:0] cap_bits;
   logic        fmt_seen;
   logic [31:0] file_pos;
   logic [31:0] payload_remaining;
   logic [31:0] data_size_seen;
   logic [31:0] data_offset_seen;

   // sender and receiver pacing
   int         burst_left = 0;
   int         gap_left = 0;
   int         hold_request = 0;
   int         hold_left = 0;
   logic [15:0] stall_pattern = 16'hFFFF;
   logic [3:0]  pattern_pos = 4'd0;

   // bookkeeping
   int mismatches = 0;
   int idle_cycles = 0;
   int bytes_queued = 0;
   int files_sent = 0;
   int settings_used = 1;
   int status_seen[16];

   // ------------------------------------------------------------------
   // scoreboard model of the parser
   // ------------------------------------------------------------------

   // a byte flagged first_byte wipes everything but the format registers
   function automatic void restart_parse();
      file_phase        = PH_RIFF;
      byte_count        = '0;
      tag_window        = '0;
      size_window       = '0;
      skip_count        = '0;
      cap_format        = '0;
      cap_channels      = '0;
      cap_rate          = '0;
      cap_bits          = '0;
      fmt_seen          = 1'b0;
      file_pos          = '0;
      payload_remaining = '0;
      data_size_seen    = '0;
      data_offset_seen  = '0;
   endfunction

   // chunk body skip, pad byte pending in bit 0 of the byte counter
   function automatic void begin_skip(logic [31:0] n, logic pad);
      skip_count = n;
      byte_count = {3'b000, pad};
      file_phase = (n == 0 && !pad) ? PH_CID : PH_SKIP;
   endfunction

   // works out the result for one accepted byte and queues it
   task automatic parse_byte(logic [7:0] b, logic first, logic fin);
      result_type res;
      int         k;
      res = '0;
      res.status = ST_HEADER;
      if (first)
         restart_parse();
      file_pos = file_pos + 1;

      case (file_phase)
         PH_RIFF, PH_WAVE: begin
            tag_window = {tag_window[23:0], b};
            byte_count = byte_count + 4'd1;
            if (byte_count == FIELD_BYTES) begin
               byte_count = '0;
               if (tag_window != ((file_phase == PH_RIFF) ? TAG_RIFF : TAG_WAVE)) begin
                  res.status = ST_BAD_TAG;
                  file_phase = PH_DONE;
               end else begin
                  file_phase = (file_phase == PH_RIFF) ? PH_RSIZE : PH_CID;
               end
            end
         end
         PH_RSIZE: begin
            // riff size is not checked
            byte_count = byte_count + 4'd1;
            if (byte_count == FIELD_BYTES) begin
               byte_count = '0;
               file_phase = PH_WAVE;
            end
         end
         PH_CID: begin
            tag_window = {tag_window[23:0], b};
            byte_count = byte_count + 4'd1;
            if (byte_count == FIELD_BYTES) begin
               byte_count = '0;
               file_phase = PH_CSIZE;
            end
         end
         PH_CSIZE: begin
            // little-endian size
            size_window = {b, size_window[31:8]};
            byte_count = byte_count + 4'd1;
            if (byte_count == FIELD_BYTES) begin
               byte_count = '0;
               if (tag_window == TAG_FMT) begin
                  if (size_window < FMT_BYTES) begin
                     res.status = ST_SHORT_FMT;
                     file_phase = PH_DONE;
                  end else begin
                     file_phase = PH_FMT;
                  end
               end else if (tag_window == TAG_DATA) begin
                  data_size_seen = size_window;
                  data_offset_seen = file_pos;
                  if (!fmt_seen) begin
                     res.status = ST_DATA_BEFORE_FMT;
                     file_phase = PH_DONE;
                  end else if (cap_format != required_fmt.format ||
                               cap_channels != required_fmt.channels ||
                               cap_rate != required_fmt.rate ||
                               cap_bits != required_fmt.bits || size_window == 0) begin
                     res.status = ST_UNSUPPORTED;
                     file_phase = PH_DONE;
                  end else begin
                     res.status = ST_ACCEPTED;
                     payload_remaining = size_window;
                     file_phase = PH_PAYLOAD;
                  end
               end else begin
                  begin_skip(size_window, size_window[0]);
               end
            end
         end
         PH_FMT: begin
            k = int'(byte_count);
            case (k)
               0: cap_format[7:0] = b;
               1: cap_format[15:8] = b;
               2: cap_channels[7:0] = b;
               3: cap_channels[15:8] = b;
               4, 5, 6, 7: cap_rate[8*(k-4) +: 8] = b;
               14: cap_bits[7:0] = b;
               15: cap_bits[15:8] = b;
               default: ;
            endcase
            if (byte_count == FMT_LAST) begin
               fmt_seen = 1'b1;
               begin_skip(size_window - FMT_BYTES, size_window[0]);
            end else begin
               byte_count = byte_count + 4'd1;
            end
         end
         PH_SKIP: begin
            if (skip_count > 0)
               skip_count = skip_count - 1;
            else
               byte_count = '0;
            if (skip_count == 0 && byte_count == 0)
               file_phase = PH_CID;
         end
         PH_PAYLOAD: begin
            res.status = ST_PAYLOAD;
            res.payload_byte = b;
            payload_remaining = payload_remaining - 1;
            if (payload_remaining == 0 || fin) begin
               res.payload_last = 1'b1;
               file_phase = PH_DONE;
            end
         end
         default: begin
            res.status = ST_IGNORED;
            file_phase = PH_DONE;
         end
      endcase

      // end of file inside the header reports truncation unless something else was said
      if (fin && file_phase != PH_DONE) begin
         if (res.status == ST_HEADER)
            res.status = ST_TRUNCATED;
         file_phase = PH_DONE;
      end

      res.data_size = data_size_seen;
      res.data_offset = data_offset_seen;
      expected_results.push_back(res);
   endtask

   // ------------------------------------------------------------------
   // driver: bursts of transactions with random gaps
   // ------------------------------------------------------------------
   always @(posedge clock) begin : drive_bytes
      file_byte_type nxt;
      logic          offer;
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready)
            parse_byte(req.data_byte, req.first_byte, req.final_byte);
         if (!req.valid || req.ready) begin
            offer = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_bytes.size() > 0) begin
               nxt = pending_bytes.pop_front();
               offer = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else if ($urandom_range(0, 7) == 0) begin
                  // long stretch with no idling
                  burst_left = $urandom_range(64, 160);
                  gap_left = 0;
               end else begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = $urandom_range(0, 10);
               end
            end
            req.valid <= offer;
            if (offer) begin
               req.data_byte <= nxt.data_byte;
               req.first_byte <= nxt.first_byte;
               req.final_byte <= nxt.final_byte;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // monitor: field checks against the oldest expectation, plus ready pacing
   // ------------------------------------------------------------------
   function automatic void compare_field(string name, logic [31:0] due, logic [31:0] got);
      if (due !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, due, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      result_type due;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            status_seen[rsp.status]++;
            if (expected_results.size() == 0) begin
               $error("rsp transaction with no result expected, status 0x%0h", rsp.status);
               mismatches++;
            end else begin
               due = expected_results.pop_front();
               compare_field("status", 32'(due.status), 32'(rsp.status));
               compare_field("payload_byte", 32'(due.payload_byte), 32'(rsp.payload_byte));
               compare_field("payload_last", 32'(due.payload_last), 32'(rsp.payload_last));
               compare_field("data_size", due.data_size, rsp.data_size);
               compare_field("data_offset", due.data_offset, rsp.data_offset);
            end
         end
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            // long hold-off so the parser backs up into the req side
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            if (pattern_pos == 0) begin
               case ($urandom_range(0, 3))
                  0: stall_pattern = 16'hFFFF;
                  1: stall_pattern = 16'($urandom);
                  2: stall_pattern = 16'($urandom | $urandom);
                  default: stall_pattern = 16'($urandom & $urandom);
               endcase
            end
            rsp.ready <= stall_pattern[pattern_pos];
            pattern_pos = pattern_pos + 4'd1;
         end
      end
   end

   // watchdog on cycles with no transaction anywhere
   always @(posedge clock) begin : watchdog
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL wave_header_parser");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // file building
   // ------------------------------------------------------------------

   // tags go out first character first
   function automatic void put_tag(logic [31:0] tag);
      for (int i = 3; i >= 0; i--)
         file_buf.push_back(tag[8*i +: 8]);
   endfunction

   function automatic void put_le(logic [31:0] value, int n);
      for (int i = 0; i < n; i++)
         file_buf.push_back(value[8*i +: 8]);
   endfunction

   function automatic void put_rand(int n);
      repeat (n) file_buf.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void put_riff_head();
      put_tag(TAG_RIFF);
      put_rand(4);
      put_tag(TAG_WAVE);
   endfunction

   // fmt chunk of at least sixteen bytes, byte rate and block align random
   function automatic void put_fmt(want_type f, int size);
      put_tag(TAG_FMT);
      put_le(size, 4);
      put_le({16'h0000, f.format}, 2);
      put_le({16'h0000, f.channels}, 2);
      put_le(f.rate, 4);
      put_rand(6);
      put_le({16'h0000, f.bits}, 2);
      put_rand(size - 16 + size % 2);
   endfunction

   // chunk the parser skips, with its pad byte
   function automatic void put_chunk(logic [31:0] id, int size);
      put_tag(id);
      put_le(size, 4);
      put_rand(size + size % 2);
   endfunction

   function automatic void put_data_head(logic [31:0] size);
      put_tag(TAG_DATA);
      put_le(size, 4);
   endfunction

   function automatic void ship_file(bit with_first, bit with_final);
      foreach (file_buf[i])
         pending_bytes.push_back('{file_buf[i], with_first && i == 0,
                                   with_final && i == file_buf.size() - 1});
      bytes_queued += file_buf.size();
      files_sent++;
      file_buf.delete();
   endfunction

   function automatic want_type any_fmt();
      any_fmt = '{16'($urandom), 16'($urandom), $urandom, 16'($urandom)};
   endfunction

   // one format field off by a single bit
   function automatic want_type detune_fmt(want_type f);
      case ($urandom_range(0, 3))
         0: f.format = f.format ^ (16'd1 << $urandom_range(0, 15));
         1: f.channels = f.channels ^ (16'd1 << $urandom_range(0, 15));
         2: f.rate = f.rate ^ (32'd1 << $urandom_range(0, 31));
         default: f.bits = f.bits ^ (16'd1 << $urandom_range(0, 15));
      endcase
      return f;
   endfunction

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   task automatic directed_files();
      want_type pcm;
      want_type odd;
      pcm = required_fmt;

      // right after reset with no first byte, payload of both byte extremes
      put_riff_head();
      put_fmt(pcm, 16);
      put_data_head(4);
      file_buf.push_back(8'h00);
      file_buf.push_back(8'hFF);
      file_buf.push_back(8'h00);
      file_buf.push_back(8'hFF);
      ship_file(0, 0);

      // bad riff tag, then a couple of ignored bytes
      put_tag(32'h5249_4658);
      put_rand(2);
      ship_file(1, 0);

      // bad wave tag
      put_tag(TAG_RIFF);
      put_rand(4);
      put_tag(32'h5741_5646);
      ship_file(1, 0);

      // fmt chunk too short, final byte lands after the parse ended
      put_riff_head();
      put_tag(TAG_FMT);
      put_le(15, 4);
      put_rand(1);
      ship_file(1, 1);

      // data chunk before any fmt, behind an odd-sized list chunk
      put_riff_head();
      put_chunk(32'h4C49_5354, 3);
      put_data_head(8);
      ship_file(1, 0);

      // format code the registers do not allow
      odd = pcm;
      odd.format = 16'd3;
      put_riff_head();
      put_fmt(odd, 16);
      put_data_head(4);
      ship_file(1, 0);

      // zero-sized data chunk
      put_riff_head();
      put_fmt(pcm, 16);
      put_data_head(0);
      put_rand(1);
      ship_file(1, 0);

      // empty unknown chunk, odd fmt overwritten by a later fmt, final on last payload
      put_riff_head();
      put_chunk(32'h6A75_6E6B, 0);
      put_fmt(any_fmt(), 17);
      put_fmt(pcm, 18);
      put_data_head(5);
      put_rand(5);
      ship_file(1, 1);

      // header cut short inside the fmt chunk
      put_riff_head();
      put_fmt(pcm, 16);
      while (file_buf.size() > 30)
         void'(file_buf.pop_back());
      ship_file(1, 1);

      // file ends on the last size byte of the data chunk
      put_riff_head();
      put_fmt(pcm, 16);
      put_data_head(10);
      ship_file(1, 1);

      // payload cut by the end of the file
      put_riff_head();
      put_fmt(pcm, 16);
      put_data_head(100);
      put_rand(3);
      ship_file(1, 1);

      // largest odd chunk size, only a new file gets out of the skip
      put_riff_head();
      put_tag(32'h6A75_6E6B);
      put_le(32'hFFFF_FFFF, 4);
      put_rand(5);
      ship_file(1, 0);

      // normal file with stray bytes after the payload
      put_riff_head();
      put_fmt(pcm, 16);
      put_data_head(3);
      put_rand(6);
      ship_file(1, 0);
   endtask

   task automatic random_file();
      int          kind;
      int          body;
      flaw_type    flaw;
      logic [31:0] dsize;
      bit          fin;
      want_type    f;
      kind = $urandom_range(0, 99);
      if (kind >= 85) begin
         // plain noise with random first and final flags
         repeat ($urandom_range(1, 20)) begin
            pending_bytes.push_back('{8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                                      $urandom_range(0, 7) == 0});
            bytes_queued++;
         end
         return;
      end
      flaw = FLAW_NONE;
      if (kind >= 70)
         flaw = flaw_type'($urandom_range(1, 4));
      f = required_fmt;
      if ($urandom_range(0, 7) == 0)
         f = detune_fmt(f);

      put_riff_head();
      repeat ($urandom_range(0, 2)) put_chunk($urandom, $urandom_range(0, 9));
      if (flaw == FLAW_SHORT_FMT) begin
         put_tag(TAG_FMT);
         put_le($urandom_range(0, 15), 4);
         put_rand($urandom_range(0, 3));
         ship_file(1, $urandom_range(0, 1));
         return;
      end
      if (flaw != FLAW_NO_FMT) begin
         if ($urandom_range(0, 9) == 0)
            put_fmt(any_fmt(), 16 + $urandom_range(0, 3));
         put_fmt(f, 16 + $urandom_range(0, 5));
         if ($urandom_range(0, 3) == 0)
            put_chunk($urandom, $urandom_range(0, 5));
      end

      // data sizes stay small, now and then zero or huge
      case ($urandom_range(0, 19))
         0: dsize = 0;
         1: dsize = $urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom | 32'h100);
         default: dsize = $urandom_range(1, 24);
      endcase
      fin = $urandom_range(0, 1);
      if (dsize > 24) begin
         body = $urandom_range(1, 30);
         fin = 1;
      end else if (dsize == 0 || $urandom_range(0, 3) != 0) begin
         body = dsize + $urandom_range(0, 2);
      end else begin
         body = $urandom_range(0, dsize - 1);
         fin = 1;
      end
      put_data_head(dsize);
      put_rand(body);

      if (flaw == FLAW_BIT) begin
         body = $urandom_range(0, file_buf.size() - 1);
         file_buf[body] = file_buf[body] ^ (8'd1 << $urandom_range(0, 7));
      end else if (flaw == FLAW_CUT) begin
         body = $urandom_range(1, file_buf.size());
         while (file_buf.size() > body)
            void'(file_buf.pop_back());
         fin = 1;
      end
      ship_file($urandom_range(0, 31) != 0, fin);
   endtask

   task automatic random_files(int n);
      int stop_at;
      stop_at = bytes_queued + n;
      while (bytes_queued < stop_at)
         random_file();
   endtask

   // sender stays quiet until every result is back, then the pipeline empties
   task automatic drain_and_settle();
      do
         @(posedge clock);
      while (pending_bytes.size() != 0 || req.valid || expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_WANT_FORMAT:   required_fmt.format = value[15:0];
         CSR_WANT_CHANNELS: required_fmt.channels = value[15:0];
         CSR_WANT_RATE:     required_fmt.rate = value;
         CSR_WANT_BITS:     required_fmt.bits = value[15:0];
      endcase
   endtask

   task automatic set_required(want_type w);
      drain_and_settle();
      write_reg(CSR_WANT_FORMAT, {16'h0000, w.format});
      write_reg(CSR_WANT_CHANNELS, {16'h0000, w.channels});
      write_reg(CSR_WANT_RATE, w.rate);
      write_reg(CSR_WANT_BITS, {16'h0000, w.bits});
      settings_used++;
   endtask

   initial begin : stimulus
      // every block input known from time zero
      reset = 1'b1;
      req.valid = 1'b0;
      req.data_byte = '0;
      req.first_byte = 1'b0;
      req.final_byte = 1'b0;
      rsp.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_WANT_FORMAT;
      csr_wdata = '0;
      foreach (status_seen[i])
         status_seen[i] = 0;
      required_fmt = '{RESET_FORMAT, RESET_CHANNELS, RESET_RATE, RESET_BITS};
      restart_parse();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset register values
      directed_files();
      random_files(500);

      // all registers at their maximum, receiver holds off while bytes keep coming
      set_required('{16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF});
      hold_request = LONG_HOLD;
      random_files(400);

      // all registers zero
      set_required('{16'h0000, 16'h0000, 32'h0000_0000, 16'h0000});
      random_files(350);

      // random register values
      set_required(any_fmt());
      random_files(350);

      // ordinary pcm setup, mono 48k 24 bit
      set_required('{RESET_FORMAT, 16'd1, 32'd48000, 16'd24});
      random_files(350);

      drain_and_settle();

      $display("covered %0d files, %0d bytes, %0d format register settings",
               files_sent, bytes_queued, settings_used);
      $display("seen: %0d accepted, %0d payload, %0d header errors, %0d truncated, %0d ignored",
               status_seen[ST_ACCEPTED], status_seen[ST_PAYLOAD],
               status_seen[ST_BAD_TAG] + status_seen[ST_SHORT_FMT] +
               status_seen[ST_DATA_BEFORE_FMT] + status_seen[ST_UNSUPPORTED],
               status_seen[ST_TRUNCATED], status_seen[ST_IGNORED]);
      if (mismatches == 0)
         $display("PASS wave_header_parser");
      else
         $display("FAIL wave_header_parser");
      $finish;
   end

endmodule
